// ===== design/si3_pkg.sv =====
// si3_pkg: shared types, sizes and coefficient tables of the stereo interpolator
// used by every module of the block
package si3_pkg;

    localparam int LOWPASS_TAPS_DEF = 78;
    localparam int PHASE_TAPS_DEF   = 48;
    localparam int DIRECT_DELAY_DEF = 24;
    localparam int LPF_LEN          = 78;
    localparam int PH_LEN           = 48;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [1:0]         phase;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_DIRECT = 2'd0,
        PH_THIRD  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    function automatic logic signed [15:0] lpf_coef(input int k);
        logic signed [15:0] t [0:LPF_LEN-1];
        t = '{
            -16'sd4, 16'sd8, -16'sd11, 16'sd13, -16'sd13, 16'sd9, 16'sd0, -16'sd13,
            16'sd30, -16'sd48, 16'sd62, -16'sd68, 16'sd62, -16'sd40, 16'sd0, 16'sd54,
            -16'sd116, 16'sd176, -16'sd220, 16'sd233, -16'sd205, 16'sd127, 16'sd0,
            -16'sd165, 16'sd349, -16'sd520, 16'sd643, -16'sd681, 16'sd599, -16'sd375,
            16'sd0, 16'sd515, -16'sd1141, 16'sd1830, -16'sd2523, 16'sd3153, -16'sd3658,
            16'sd3983, 16'sd28672, 16'sd3983, -16'sd3658, 16'sd3153, -16'sd2523,
            16'sd1830, -16'sd1141, 16'sd515, 16'sd0, -16'sd375, 16'sd599, -16'sd681,
            16'sd643, -16'sd520, 16'sd349, -16'sd165, 16'sd0, 16'sd127, -16'sd205,
            16'sd233, -16'sd220, 16'sd176, -16'sd116, 16'sd54, 16'sd0, -16'sd40,
            16'sd62, -16'sd68, 16'sd62, -16'sd48, 16'sd30, -16'sd13, 16'sd0, 16'sd9,
            -16'sd13, 16'sd13, -16'sd11, 16'sd8, -16'sd4, 16'sd0};
        if (k < LPF_LEN)
            return t[k];
        return 16'sd0;
    endfunction

    function automatic logic signed [15:0] second_coef(input int k);
        logic signed [15:0] t [0:PH_LEN-1];
        t = '{
            -16'sd2, 16'sd5, -16'sd8, 16'sd14, -16'sd23, 16'sd35, -16'sd51, 16'sd73,
            -16'sd101, 16'sd136, -16'sd182, 16'sd239, -16'sd309, 16'sd396, -16'sd503,
            16'sd636, -16'sd803, 16'sd1015, -16'sd1295, 16'sd1682, -16'sd2260,
            16'sd3237, -16'sd5324, 16'sd13511, 16'sd27079, -16'sd6698, 16'sd3739,
            -16'sd2523, 16'sd1847, -16'sd1410, 16'sd1100, -16'sd867, 16'sd687,
            -16'sd544, 16'sd429, -16'sd336, 16'sd260, -16'sd199, 16'sd150, -16'sd112,
            16'sd81, -16'sd58, 16'sd40, -16'sd26, 16'sd17, -16'sd10, 16'sd6, -16'sd3};
        if (k < PH_LEN)
            return t[k];
        return 16'sd0;
    endfunction

    // the third table is the second one time-reversed
    function automatic logic signed [15:0] third_coef(input int k);
        if (k < PH_LEN)
            return second_coef(PH_LEN - 1 - k);
        return 16'sd0;
    endfunction

    // arithmetic shift by 15 and saturate to 16 bits
    function automatic logic signed [15:0] sat_q15(input logic signed [31:0] acc);
        logic signed [16:0] v;
        v = acc[31:15];
        if (v > 17'sd32767)
            return 16'sh7fff;
        if (v < -17'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== design/si3_front.sv =====
// si3_front: input stage, takes sample pairs into a two-entry queue
// depends on si3_pkg
module si3_front
    import si3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_take,
    output in_item_t q_data
);

    in_item_t   slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_take && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> in_stall) else $error("full queue lost stall");

endmodule

// ===== design/si3_back.sv =====
// si3_back: filter engine, one MAC a cycle while scanning, over histories in memory
// depends on si3_pkg
module si3_back
    import si3_pkg::*;
#(
    parameter int LOWPASS_TAPS = LOWPASS_TAPS_DEF,
    parameter int PHASE_TAPS   = PHASE_TAPS_DEF,
    parameter int DIRECT_DELAY = DIRECT_DELAY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_take,
    input  in_item_t  q_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int LP_DEPTH = PHASE_TAPS + DIRECT_DELAY;
    localparam int IW = $clog2(LOWPASS_TAPS);
    localparam int LW = $clog2(LP_DEPTH);
    localparam int KMAX = (LOWPASS_TAPS > PHASE_TAPS + 1) ? LOWPASS_TAPS : PHASE_TAPS + 1;
    localparam int KW = $clog2(KMAX + 1);
    localparam int NW = (IW > LW) ? IW : LW;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRIN  = 6'b000010,
        S_LPF   = 6'b000100,
        S_WRLP  = 6'b001000,
        S_PHASE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // circular histories, one per channel; zero fill via counts
    logic signed [15:0] ih_mem [0:1][0:LOWPASS_TAPS-1];
    logic signed [15:0] lh_mem [0:1][0:LP_DEPTH-1];
    logic [IW-1:0] ih_head_reg;
    logic [LW-1:0] lh_head_reg;
    logic [KW-1:0] ih_fill_reg;
    logic [LW:0]   lh_fill_reg;

    logic          ch_reg;
    logic [KW-1:0] k_reg;
    logic          rd_ok_reg;
    logic signed [15:0] rd_reg;
    logic signed [15:0] ca_reg, cb_reg;
    logic signed [31:0] pa_reg, pb_reg, acc_a_reg, acc_b_reg;
    logic          mac_v_reg, mul_v_reg;
    logic signed [15:0] in_l_reg, in_r_reg;
    logic signed [15:0] res_reg [0:2][0:1];
    logic [1:0]    ph_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    logic [KW-1:0] drain_reg;

    function automatic logic [IW-1:0] ih_wrap(input logic [NW:0] a);
        return (a >= LOWPASS_TAPS) ? IW'(a - LOWPASS_TAPS) : a[IW-1:0];
    endfunction
    function automatic logic [LW-1:0] lh_wrap(input logic [NW:0] a);
        return (a >= LP_DEPTH) ? LW'(a - LP_DEPTH) : a[LW-1:0];
    endfunction

    // oldest-first position k maps behind the newest entry
    // the low-pass entry of this request is written but not yet counted in the fill
    logic [IW-1:0] ih_addr;
    logic [LW-1:0] lh_addr;
    logic          ih_valid_k, lh_valid_k;
    int unsigned   kk;
    always_comb
    begin
        kk = 32'(k_reg);
        ih_addr = ih_wrap((NW+1)'(ih_head_reg) + (NW+1)'(kk));
        ih_valid_k = (LOWPASS_TAPS - kk) <= 32'(ih_fill_reg);
        lh_addr = lh_wrap((NW+1)'(lh_head_reg) + (NW+1)'(DIRECT_DELAY + 1 + kk < LP_DEPTH ?
                  DIRECT_DELAY + 1 + kk : DIRECT_DELAY + 1 + kk - LP_DEPTH));
        lh_valid_k = (PHASE_TAPS - kk) <= 32'(lh_fill_reg) + 32'd1;
    end

    logic [LW-1:0] dir_addr;
    logic          dir_ok;
    assign dir_addr = lh_wrap((NW+1)'(lh_head_reg) + (NW+1)'(PHASE_TAPS));
    assign dir_ok   = DIRECT_DELAY <= 32'(lh_fill_reg);

    logic in_scan, lp_scan, dir_step;
    assign in_scan  = (state_reg == S_LPF)   && (32'(k_reg) < LOWPASS_TAPS);
    assign lp_scan  = (state_reg == S_PHASE) && (32'(k_reg) < PHASE_TAPS);
    assign dir_step = (state_reg == S_PHASE) && (32'(k_reg) == PHASE_TAPS);

    // scan of the MAC pipe: k steps, then drain the three pipe stages
    logic scan_end;
    assign scan_end = (state_reg == S_LPF)   ? (32'(k_reg) >= LOWPASS_TAPS) :
                      (32'(k_reg) >= PHASE_TAPS + 1);

    // output register free to take the next phase
    logic emit_go;
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRIN)
        begin
            ih_mem[0][ih_head_reg] <= in_l_reg;
            ih_mem[1][ih_head_reg] <= in_r_reg;
        end
        if (state_reg == S_WRLP)
            lh_mem[ch_reg][lh_head_reg] <= sat_q15(acc_a_reg);
    end

    // registered memory read
    always_ff @(posedge clk)
    begin
        if (in_scan)
            rd_reg <= ih_mem[ch_reg][ih_addr];
        else if (dir_step)
            rd_reg <= lh_mem[ch_reg][dir_addr];
        else
            rd_reg <= lh_mem[ch_reg][lh_addr];
        rd_ok_reg <= in_scan ? ih_valid_k : (dir_step ? dir_ok : lh_valid_k);
        ca_reg    <= in_scan ? lpf_coef(32'(k_reg)) : third_coef(32'(k_reg));
        cb_reg    <= second_coef(32'(k_reg));
    end

    // multiply then accumulate, one register each
    always_ff @(posedge clk)
    begin
        pa_reg <= rd_ok_reg ? 32'(ca_reg * rd_reg) : 32'sd0;
        pb_reg <= rd_ok_reg ? 32'(cb_reg * rd_reg) : 32'sd0;
        if (state_reg == S_WRIN || state_reg == S_WRLP ||
            (state_reg == S_PHASE && scan_end && drain_reg == KW'(1)))
        begin
            acc_a_reg <= 32'sd0;
            acc_b_reg <= 32'sd0;
        end
        else if (mul_v_reg)
        begin
            acc_a_reg <= acc_a_reg + pa_reg;
            acc_b_reg <= acc_b_reg + pb_reg;
        end
        if (dir_step)
            res_reg[0][ch_reg] <= 16'sd0;
        if (state_reg == S_PHASE && k_reg == KW'(PHASE_TAPS + 1) && drain_reg == '0)
            res_reg[0][ch_reg] <= rd_ok_reg ? rd_reg : 16'sd0;
        if (state_reg == S_PHASE && drain_reg == KW'(1))
        begin
            res_reg[1][ch_reg] <= sat_q15(acc_a_reg);
            res_reg[2][ch_reg] <= sat_q15(acc_b_reg);
        end
        if (q_take)
        begin
            in_l_reg <= q_data.left_in;
            in_r_reg <= q_data.right_in;
        end
        if (emit_go)
        begin
            out_reg.left_out  <= res_reg[ph_reg][0];
            out_reg.right_out <= res_reg[ph_reg][1];
            out_reg.phase     <= ph_reg;
            out_reg.last      <= (ph_reg == PH_SECOND);
        end
    end

    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_WRIN;
            S_WRIN:  state_next = S_LPF;
            S_LPF:   if (scan_end && drain_reg == KW'(1)) state_next = S_WRLP;
            S_WRLP:  state_next = S_PHASE;
            S_PHASE:
                if (scan_end && drain_reg == KW'(1))
                    state_next = ch_reg ? S_EMIT : S_LPF;
            S_EMIT:
                if (emit_go && ph_reg == PH_SECOND)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ih_head_reg   <= '0;
            lh_head_reg   <= '0;
            ih_fill_reg   <= '0;
            lh_fill_reg   <= '0;
            ch_reg        <= 1'b0;
            k_reg         <= '0;
            drain_reg     <= '0;
            mac_v_reg     <= 1'b0;
            mul_v_reg     <= 1'b0;
            ph_reg        <= PH_DIRECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mac_v_reg     <= in_scan || lp_scan;
            mul_v_reg     <= mac_v_reg;
            out_valid_reg <= emit_go || (out_valid_reg && out_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    ch_reg <= 1'b0;
                    ph_reg <= PH_DIRECT;
                end
                S_WRIN:
                begin
                    ih_head_reg <= ih_wrap((NW+1)'(ih_head_reg) + (NW+1)'(1));
                    if (32'(ih_fill_reg) < LOWPASS_TAPS)
                        ih_fill_reg <= ih_fill_reg + KW'(1);
                    k_reg     <= '0;
                    drain_reg <= '0;
                end
                S_LPF, S_PHASE:
                begin
                    if (!scan_end)
                        k_reg <= k_reg + KW'(1);
                    else if (drain_reg == '0)
                        drain_reg <= KW'(3);
                    else
                        drain_reg <= drain_reg - KW'(1);
                    if (scan_end && drain_reg == KW'(1))
                    begin
                        k_reg <= '0;
                        if (state_reg == S_PHASE && !ch_reg)
                            ch_reg <= 1'b1;
                        if (state_reg == S_PHASE && ch_reg)
                        begin
                            lh_head_reg <= lh_wrap((NW+1)'(lh_head_reg) + (NW+1)'(1));
                            if (32'(lh_fill_reg) < LP_DEPTH)
                                lh_fill_reg <= lh_fill_reg + (LW+1)'(1);
                        end
                    end
                end
                S_WRLP:
                begin
                    k_reg     <= '0;
                    drain_reg <= '0;
                end
                S_EMIT:
                begin
                    if (emit_go)
                        ph_reg <= (ph_reg == PH_SECOND) ? PH_DIRECT : ph_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped under stall");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == S_IDLE) else $error("request taken while busy");
    a_phase_rng: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg != 2'd3) else $error("phase counter out of range");

endmodule

// ===== design/stereo_interpolate_by_3.sv =====
// stereo_interpolate_by_3: top level of the stereo interpolator by three
// depends on si3_pkg, si3_front, si3_back
//
// Usage: each request on the input channel (in_valid, in_stall, in_data)
// carries one stereo Q15 pair at the low rate. Three result requests follow
// on the output channel (out_valid, out_stall, out_data), phases 0, 1, 2,
// with last set on the third.
// Throughput: one MAC per cycle through a single multiplier pair while a
// scan runs; the low-pass and phase scans of both channels set the time
// per pair, and the engine takes a new pair only after its three results.
// The first result follows the phase scan of the second channel; the other
// two follow on the next cycles when not stalled.
// A two-entry queue in front takes new pairs while the engine works.
// Reset clears both histories at once through fill counts; no clearing pass.
// A stalled receiver holds the output register; the engine waits and the
// input queue stalls when full.
module stereo_interpolate_by_3
    import si3_pkg::*;
#(
    parameter int LOWPASS_TAPS = LOWPASS_TAPS_DEF,
    parameter int PHASE_TAPS   = PHASE_TAPS_DEF,
    parameter int DIRECT_DELAY = DIRECT_DELAY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic     q_valid, q_take;
    in_item_t q_data;

    si3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_data   (q_data)
    );

    si3_back #(
        .LOWPASS_TAPS (LOWPASS_TAPS),
        .PHASE_TAPS   (PHASE_TAPS),
        .DIRECT_DELAY (DIRECT_DELAY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
